### rtl/mmss_pkg.sv
// Package: constants and transaction types for the max-min spacing search unit.
`timescale 1ns / 1ps
`default_nettype none
package mmss_pkg;

  localparam int MAX_STALLS = 1024;
  localparam int POS_BITS   = 30;
  localparam int ADDR_BITS  = $clog2(MAX_STALLS);
  localparam int CNT_BITS   = $clog2(MAX_STALLS + 1);
  localparam int COW_BITS   = 11;
  localparam int SRCH_BITS  = POS_BITS + 2;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                last_stall;
  } mmss_in_t;

  typedef struct packed {
    logic [POS_BITS-1:0] largest_min_gap;
    logic                feasible;
  } mmss_out_t;

endpackage
`default_nettype wire

### rtl/max_min_spacing_search_unit.sv
// Top level: stall store plus binary search over greedy placement trials.
// Search: a stall without last_stall is only stored; after a last_stall transaction
//   the result comes from a binary search of T trials (up to about 31), each one pass
//   over the N stalls held in memory; with too few stalls no search is run.
// Throughput: one stall per cycle while loading; one search at a time.
// Reset: synchronous active-low rst_n clears control, counters and cow_count (to 2);
//   the stall memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module max_min_spacing_search_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mmss_pkg::mmss_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mmss_pkg::mmss_out_t                 out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mmss_pkg::COW_BITS-1:0]  cfg_wr_data
);
  import mmss_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_CHECK, S_SEARCH, S_RUN, S_EMIT} state_t;

  localparam logic signed [SRCH_BITS-1:0] ONE_S = SRCH_BITS'(1);
  localparam logic [COW_BITS-1:0]         MIN_COW = COW_BITS'(2);

  state_t                       state_r, state_nxt;
  logic [COW_BITS-1:0]          cow_r, cow_nxt;
  logic [CNT_BITS-1:0]          total_r, total_nxt;
  logic [POS_BITS-1:0]          smallest_r, smallest_nxt;
  logic [POS_BITS-1:0]          first_r, first_nxt;
  logic [POS_BITS-1:0]          prev_r, prev_nxt;
  logic signed [SRCH_BITS-1:0]  low_r, low_nxt;
  logic signed [SRCH_BITS-1:0]  high_r, high_nxt;
  logic [POS_BITS-1:0]          mid_r, mid_nxt;
  logic [POS_BITS-1:0]          best_r, best_nxt;
  logic                         feas_r, feas_nxt;
  logic [POS_BITS-1:0]          last_r, last_nxt;
  logic [COW_BITS-1:0]          placed_r, placed_nxt;
  logic [CNT_BITS-1:0]          idx_r, idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mmss_out_t                    out_r, out_nxt;

  logic [POS_BITS-1:0]          mem [MAX_STALLS];
  logic [POS_BITS-1:0]          rd_data_r;
  logic                         rd_en;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic                         wr_en;

  logic                         in_acc;
  logic [COW_BITS-1:0]          need_c;
  logic [POS_BITS-1:0]          pos_c;
  logic [POS_BITS-1:0]          gap_c;
  logic [POS_BITS-1:0]          diff_c;
  logic signed [SRCH_BITS-1:0]  sum_c;
  logic                         fits_c;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign need_c    = (cow_r < MIN_COW) ? MIN_COW : cow_r;
  assign pos_c     = (in_data.position < prev_r) ? prev_r : in_data.position;
  assign gap_c     = pos_c - prev_r;
  assign diff_c    = rd_data_r - last_r;
  assign sum_c     = low_r + high_r;
  assign wr_en     = in_acc && (total_r < CNT_BITS'(MAX_STALLS));

  always_comb begin
    state_nxt     = state_r;
    cow_nxt       = cfg_wr_en ? cfg_wr_data : cow_r;
    total_nxt     = total_r;
    smallest_nxt  = smallest_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    feas_nxt      = feas_r;
    last_nxt      = last_r;
    placed_nxt    = placed_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[ADDR_BITS-1:0];
    fits_c        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    case (state_r)
      S_LOAD: begin
        if (wr_en) begin
          total_nxt = total_r + CNT_BITS'(1);
          prev_nxt  = pos_c;
          if (total_r == '0) begin
            first_nxt = in_data.position;
            prev_nxt  = in_data.position;
          end else if (gap_c < smallest_r) begin
            smallest_nxt = gap_c;
          end
        end
        if (in_acc && in_data.last_stall) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        best_nxt = '0;
        if (total_r >= CNT_BITS'(need_c)) begin
          feas_nxt  = 1'b1;
          low_nxt   = $signed({2'b00, smallest_r});
          high_nxt  = $signed({2'b00, prev_r - first_r});
          state_nxt = S_SEARCH;
        end else begin
          feas_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_SEARCH: begin
        if (low_r <= high_r) begin
          mid_nxt    = sum_c[POS_BITS:1];
          last_nxt   = first_r;
          placed_nxt = COW_BITS'(1);
          rd_en      = 1'b1;
          rd_addr    = ADDR_BITS'(1);
          idx_nxt    = CNT_BITS'(2);
          rd_vld_nxt = 1'b1;
          state_nxt  = S_RUN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RUN: begin
        if (idx_r < total_r) begin
          rd_en      = 1'b1;
          idx_nxt    = idx_r + CNT_BITS'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && (diff_c >= mid_r)) begin
          placed_nxt = placed_r + COW_BITS'(1);
          last_nxt   = rd_data_r;
          fits_c     = (placed_nxt == need_c);
        end
        if (fits_c) begin
          best_nxt   = mid_r;
          low_nxt    = $signed({2'b00, mid_r}) + ONE_S;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_SEARCH;
        end else if (!rd_vld_r) begin
          high_nxt   = $signed({2'b00, mid_r}) - ONE_S;
          rd_vld_nxt = 1'b0;
          rd_en      = 1'b0;
          state_nxt  = S_SEARCH;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.largest_min_gap = best_r;
          out_nxt.feasible        = feas_r;
          total_nxt               = '0;
          smallest_nxt            = '1;
          state_nxt               = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[total_r[ADDR_BITS-1:0]] <= pos_c;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cow_r       <= MIN_COW;
      total_r     <= '0;
      smallest_r  <= '1;
      low_r       <= '0;
      high_r      <= '0;
      best_r      <= '0;
      feas_r      <= 1'b0;
      last_r      <= '0;
      placed_r    <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cow_r       <= cow_nxt;
      total_r     <= total_nxt;
      smallest_r  <= smallest_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      best_r      <= best_nxt;
      feas_r      <= feas_nxt;
      last_r      <= last_nxt;
      placed_r    <= placed_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    mid_r   <= mid_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTH
  a_rd_vld_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_RUN))
    else $error("memory read data valid outside a trial");

  a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.feasible) |-> (out_r.largest_min_gap == '0))
    else $error("infeasible result carries a nonzero gap");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_BITS'(MAX_STALLS))
    else $error("stall count exceeds store depth");

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (low_r <= high_r))
    else $error("trial running with empty search range");
`endif

endmodule
`default_nettype wire
